[src/dls_pkg.sv]
// Shared widths, codes and a helper function for the DDA line pixel stepper.
// Used by the top level and by its checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dls_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int INC_BITS   = QUO_BITS + 1;
  localparam int PIX_BITS   = COORD_BITS + 1;
  localparam int OUT_BITS   = 12;
  localparam int STYLE_BITS = 2;
  localparam int CNT_BITS   = $clog2(QUO_BITS);
  localparam int EXT_BITS   = (PIX_BITS + 1 > OUT_BITS) ? PIX_BITS + 1 : OUT_BITS;

  // Residue-by-five helper: the offset is a multiple of five that lifts any
  // pixel coordinate to a non-negative value.
  localparam int MOD_BITS = COORD_BITS + 2;
  localparam int MOD_OFS  = ((2 ** COORD_BITS) / 5 + 1) * 5;
  localparam int MOD_NIBS = (MOD_BITS + 3) / 4;

  typedef enum logic [STYLE_BITS-1:0] {
    STYLE_SOLID  = 2'd0,
    STYLE_DOTTED = 2'd1,
    STYLE_DASHED = 2'd2,
    STYLE_THICK  = 2'd3
  } style_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Since 16 is 1 modulo 5, the sum of the hex digits keeps the residue.
  function automatic logic is_mult5(input logic signed [PIX_BITS-1:0] v);
    logic [MOD_BITS-1:0]   u;
    logic [MOD_BITS+3:0]   padded;
    logic [7:0]            s;
    u      = MOD_BITS'(v) + MOD_BITS'(MOD_OFS);
    padded = {4'b0000, u};
    s      = 8'd0;
    for (int i = 0; i < MOD_NIBS; i++) begin
      s = s + 8'(padded[4*i +: 4]);
    end
    for (int j = 0; j < 3; j++) begin
      s = 8'(s[7:4]) + 8'(s[3:0]);
    end
    return (s == 8'd0) || (s == 8'd5) || (s == 8'd10) || (s == 8'd15);
  endfunction

endpackage

`default_nettype wire

[src/dda_line_pixel_stepper.sv]
// Top level of the DDA line pixel stepper: endpoint load, shared divider,
// accumulator step and pixel emission. Depends on dls_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A load item (op 0) latches the endpoints, sets the accumulators to the start
// point and derives the per-step increments with one shared compare-subtract
// unit that produces one quotient bit per cycle, first for x and then for y;
// when both endpoints are equal it skips the division and zeroes them. A step
// item (op 1) updates the accumulators and then emits its pixel, or in thick
// style a cross of four pixels, each waiting while the output is stalled; in
// dotted and dashed style a skipped pixel is not emitted. A step with no active
// line gives nothing. The input stalls while an item is in work; the output
// register lets a finished pixel wait while the next item is taken. The start
// point is never plotted.
module dda_line_pixel_stepper (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_op,
  input  wire  [dls_pkg::COORD_BITS-1:0]       in_start_x,
  input  wire  [dls_pkg::COORD_BITS-1:0]       in_start_y,
  input  wire  [dls_pkg::COORD_BITS-1:0]       in_end_x,
  input  wire  [dls_pkg::COORD_BITS-1:0]       in_end_y,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [dls_pkg::OUT_BITS-1:0]  out_pixel_x,
  output logic signed [dls_pkg::OUT_BITS-1:0]  out_pixel_y,
  output logic                                 out_last_of_step,
  output logic                                 out_line_done,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [dls_pkg::STYLE_BITS-1:0]       cfg_line_style
);

  localparam int CB = dls_pkg::COORD_BITS;
  localparam int AB = dls_pkg::ACC_BITS;
  localparam int IB = dls_pkg::INC_BITS;
  localparam int QB = dls_pkg::QUO_BITS;
  localparam int PB = dls_pkg::PIX_BITS;
  localparam int OB = dls_pkg::OUT_BITS;
  localparam int EB = dls_pkg::EXT_BITS;
  localparam int NB = dls_pkg::CNT_BITS;

  dls_pkg::state_t         state_r, state_nxt;
  dls_pkg::style_t         style_r, style_nxt;
  logic signed [AB-1:0]    acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic signed [IB-1:0]    inc_x_r, inc_x_nxt, inc_y_r, inc_y_nxt;
  logic [CB-1:0]           steps_left_r, steps_left_nxt;
  logic [CB-1:0]           mag_x_r, mag_x_nxt, mag_y_r, mag_y_nxt;
  logic                    neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic                    div_y_r, div_y_nxt;
  logic [CB-1:0]           rem_r, rem_nxt;
  logic [QB-1:0]           quo_r, quo_nxt;
  logic [NB-1:0]           cnt_r, cnt_nxt;
  logic signed [PB-1:0]    pix_x_r, pix_x_nxt, pix_y_r, pix_y_nxt;
  logic                    done_r, done_nxt;
  logic [1:0]              emit_k_r, emit_k_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OB-1:0]    out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_done_r, out_done_nxt;

  logic                    in_accept;
  logic [CB-1:0]           ax, ay, steps;
  logic [CB-1:0]           mag_sel;
  logic [CB:0]             cand, diff;
  logic                    ge;
  logic [QB-1:0]           q_new;
  logic signed [IB-1:0]    inc_val;
  logic signed [AB-1:0]    acc_x_sum, acc_y_sum;
  logic                    visible, is_last, out_free;
  logic signed [EB-1:0]    x_ext, y_ext, px, py;

  assign in_stall  = (state_r != dls_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = out_x_r;
  assign out_pixel_y      = out_y_r;
  assign out_last_of_step = out_last_r;
  assign out_line_done    = out_done_r;

  // Endpoint magnitudes and the major-axis step count.
  assign ax    = (in_end_x >= in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
  assign ay    = (in_end_y >= in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;
  assign steps = (ax > ay) ? ax : ay;

  // Shared compare-subtract unit. The first pass yields the integer bit of
  // |d| / steps, each later pass one fraction bit.
  assign mag_sel = div_y_r ? mag_y_r : mag_x_r;
  assign cand    = (cnt_r == NB'(dls_pkg::FRAC_BITS)) ? {1'b0, mag_sel} : {rem_r, 1'b0};
  assign diff    = cand - {1'b0, steps_left_r};
  assign ge      = (cand >= {1'b0, steps_left_r});
  assign q_new   = {quo_r[QB-2:0], ge};
  assign inc_val = (div_y_r ? neg_y_r : neg_x_r) ? -$signed({1'b0, q_new})
                                                 : $signed({1'b0, q_new});

  assign acc_x_sum = acc_x_r + AB'(inc_x_r);
  assign acc_y_sum = acc_y_r + AB'(inc_y_r);

  assign out_free = !out_valid_r || !out_stall;
  assign x_ext    = EB'(pix_x_r);
  assign y_ext    = EB'(pix_y_r);

  always_comb begin
    case (style_r)
      dls_pkg::STYLE_SOLID:  visible = 1'b1;
      dls_pkg::STYLE_DOTTED: visible = pix_x_r[0];
      dls_pkg::STYLE_DASHED: visible = !dls_pkg::is_mult5(pix_x_r);
      dls_pkg::STYLE_THICK:  visible = 1'b1;
      default:               visible = 1'b1;
    endcase
    is_last = (style_r != dls_pkg::STYLE_THICK) || (emit_k_r == 2'd3);
    px = x_ext;
    py = y_ext;
    if (style_r == dls_pkg::STYLE_THICK) begin
      case (emit_k_r)
        2'd0:    begin px = x_ext;            py = y_ext;            end
        2'd1:    begin px = x_ext + EB'(1);   py = y_ext;            end
        2'd2:    begin px = x_ext;            py = y_ext + EB'(1);   end
        default: begin px = x_ext - EB'(1);   py = y_ext;            end
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    style_nxt      = style_r;
    acc_x_nxt      = acc_x_r;
    acc_y_nxt      = acc_y_r;
    inc_x_nxt      = inc_x_r;
    inc_y_nxt      = inc_y_r;
    steps_left_nxt = steps_left_r;
    mag_x_nxt      = mag_x_r;
    mag_y_nxt      = mag_y_r;
    neg_x_nxt      = neg_x_r;
    neg_y_nxt      = neg_y_r;
    div_y_nxt      = div_y_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    pix_x_nxt      = pix_x_r;
    pix_y_nxt      = pix_y_r;
    done_nxt       = done_r;
    emit_k_nxt     = emit_k_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;

    if (cfg_valid && cfg_ready) begin
      style_nxt = dls_pkg::style_t'(cfg_line_style);
    end

    case (state_r)
      dls_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_op == dls_pkg::OP_LOAD) begin
            acc_x_nxt      = $signed({1'b0, in_start_x, {dls_pkg::FRAC_BITS{1'b0}}});
            acc_y_nxt      = $signed({1'b0, in_start_y, {dls_pkg::FRAC_BITS{1'b0}}});
            steps_left_nxt = steps;
            mag_x_nxt      = ax;
            mag_y_nxt      = ay;
            neg_x_nxt      = (in_end_x < in_start_x);
            neg_y_nxt      = (in_end_y < in_start_y);
            div_y_nxt      = 1'b0;
            cnt_nxt        = NB'(dls_pkg::FRAC_BITS);
            if (steps == '0) begin
              inc_x_nxt = '0;
              inc_y_nxt = '0;
            end else begin
              state_nxt = dls_pkg::ST_DIV;
            end
          end else if (steps_left_r != '0) begin
            acc_x_nxt      = acc_x_sum;
            acc_y_nxt      = acc_y_sum;
            steps_left_nxt = steps_left_r - CB'(1);
            done_nxt       = (steps_left_r == CB'(1));
            pix_x_nxt      = PB'(acc_x_sum >>> dls_pkg::FRAC_BITS);
            pix_y_nxt      = PB'(acc_y_sum >>> dls_pkg::FRAC_BITS);
            emit_k_nxt     = 2'd0;
            state_nxt      = dls_pkg::ST_EMIT;
          end
        end
      end
      dls_pkg::ST_DIV: begin
        rem_nxt = ge ? diff[CB-1:0] : cand[CB-1:0];
        quo_nxt = q_new;
        if (cnt_r == '0) begin
          if (div_y_r) begin
            inc_y_nxt = inc_val;
            state_nxt = dls_pkg::ST_IDLE;
          end else begin
            inc_x_nxt = inc_val;
            div_y_nxt = 1'b1;
            cnt_nxt   = NB'(dls_pkg::FRAC_BITS);
          end
        end else begin
          cnt_nxt = cnt_r - NB'(1);
        end
      end
      dls_pkg::ST_EMIT: begin
        if (!visible) begin
          state_nxt = dls_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = px[OB-1:0];
          out_y_nxt     = py[OB-1:0];
          out_last_nxt  = is_last;
          out_done_nxt  = done_r;
          if (is_last) begin
            state_nxt = dls_pkg::ST_IDLE;
          end else begin
            emit_k_nxt = emit_k_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = dls_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dls_pkg::ST_IDLE;
      style_r      <= dls_pkg::STYLE_SOLID;
      steps_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      style_r      <= style_nxt;
      steps_left_r <= steps_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_x_r    <= acc_x_nxt;
    acc_y_r    <= acc_y_nxt;
    inc_x_r    <= inc_x_nxt;
    inc_y_r    <= inc_y_nxt;
    mag_x_r    <= mag_x_nxt;
    mag_y_r    <= mag_y_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    div_y_r    <= div_y_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    pix_x_r    <= pix_x_nxt;
    pix_y_r    <= pix_y_nxt;
    done_r     <= done_nxt;
    emit_k_r   <= emit_k_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

endmodule

`default_nettype wire

[src/dls_checker.sv]
// Port-level checker for the DDA line pixel stepper and its bind statement.
// Depends on dls_pkg and on the ports of dda_line_pixel_stepper.
`timescale 1ns / 1ps
`default_nettype none

module dls_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_valid,
  input wire                                 in_stall,
  input wire                                 in_op,
  input wire [dls_pkg::COORD_BITS-1:0]       in_start_x,
  input wire [dls_pkg::COORD_BITS-1:0]       in_start_y,
  input wire [dls_pkg::COORD_BITS-1:0]       in_end_x,
  input wire [dls_pkg::COORD_BITS-1:0]       in_end_y,
  input wire                                 out_valid,
  input wire                                 out_stall,
  input wire signed [dls_pkg::OUT_BITS-1:0]  out_pixel_x,
  input wire signed [dls_pkg::OUT_BITS-1:0]  out_pixel_y,
  input wire                                 out_last_of_step,
  input wire                                 out_line_done,
  input wire                                 cfg_valid,
  input wire                                 cfg_ready,
  input wire [dls_pkg::STYLE_BITS-1:0]       cfg_line_style
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output item present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_last_of_step) && $stable(out_line_done))
    else $error("stalled output item changed");

  // While a thick cross is still being emitted, no new item is taken.
  a_busy_mid_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_step |-> in_stall)
    else $error("input accepted in the middle of a step");

  // The pixels of one step follow each other and share their line_done flag.
  a_cross_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_step |=>
      out_valid && (out_line_done == $past(out_line_done)))
    else $error("pixel group of a step broken");

  // A load of a non-empty line starts the increment division.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == dls_pkg::OP_LOAD) &&
      ((in_start_x != in_end_x) || (in_start_y != in_end_y)) |=> in_stall)
    else $error("load of a line did not start the division");

endmodule

bind dda_line_pixel_stepper dls_checker u_dls_checker (.*);

`default_nettype wire

[test/dls_pixel_checker.sv]
// Scoreboard for the DDA line pixel stepper: watches the input, output and
// style-write channels, predicts every pixel and compares. Depends on dls_pkg.
`timescale 1ns / 1ps

module dls_pixel_checker (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  input  wire                                 in_stall,
  input  wire                                 in_op,
  input  wire  [dls_pkg::COORD_BITS-1:0]      in_start_x,
  input  wire  [dls_pkg::COORD_BITS-1:0]      in_start_y,
  input  wire  [dls_pkg::COORD_BITS-1:0]      in_end_x,
  input  wire  [dls_pkg::COORD_BITS-1:0]      in_end_y,
  input  wire                                 out_valid,
  input  wire                                 out_stall,
  input  wire  signed [dls_pkg::OUT_BITS-1:0] out_pixel_x,
  input  wire  signed [dls_pkg::OUT_BITS-1:0] out_pixel_y,
  input  wire                                 out_last_of_step,
  input  wire                                 out_line_done,
  input  wire                                 cfg_valid,
  input  wire                                 cfg_ready,
  input  wire  [dls_pkg::STYLE_BITS-1:0]      cfg_line_style,
  output int                                  mismatches,
  output int                                  pixels_pending,
  output int                                  pixels_checked
);

  localparam int REPORT_LIMIT = 10;
  localparam int CB = dls_pkg::COORD_BITS;
  localparam int FB = dls_pkg::FRAC_BITS;
  localparam int AB = dls_pkg::ACC_BITS;
  localparam int IB = dls_pkg::INC_BITS;
  localparam int PB = dls_pkg::PIX_BITS;
  localparam int OB = dls_pkg::OUT_BITS;

  typedef struct packed {
    logic signed [OB-1:0] x;
    logic signed [OB-1:0] y;
    logic                 last;
    logic                 done;
  } pixel_t;

  pixel_t               pixel_q [$];
  dls_pkg::style_t      cur_style;
  logic signed [AB-1:0] track_x;
  logic signed [AB-1:0] track_y;
  logic signed [IB-1:0] slope_x;
  logic signed [IB-1:0] slope_y;
  logic [PB-1:0]        moves_left;
  int                   err_cnt;
  int                   seen_cnt;

  // The quotient is truncated on the magnitude, so the sign is put back last.
  function automatic logic signed [IB-1:0] slope_of(input int d, input int span);
    longint q;
    q = (longint'(d < 0 ? -d : d) << FB) / span;
    if (d < 0) q = -q;
    return IB'(q);
  endfunction

  task automatic push_pixel(input int px, input int py, input logic last, input logic done);
    pixel_q.push_back('{x: OB'(px), y: OB'(py), last: last, done: done});
  endtask

  task automatic load_line(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                           input logic [CB-1:0] ex, input logic [CB-1:0] ey);
    int dx, dy, adx, ady, span;
    dx   = int'(ex) - int'(sx);
    dy   = int'(ey) - int'(sy);
    adx  = dx < 0 ? -dx : dx;
    ady  = dy < 0 ? -dy : dy;
    span = adx > ady ? adx : ady;
    track_x    = AB'(longint'(sx) << FB);
    track_y    = AB'(longint'(sy) << FB);
    moves_left = PB'(span);
    if (span == 0) begin
      slope_x = '0;
      slope_y = '0;
    end else begin
      slope_x = slope_of(dx, span);
      slope_y = slope_of(dy, span);
    end
  endtask

  task automatic advance_line();
    logic signed [AB-1:0] fx, fy;
    int   px, py;
    logic done;
    if (moves_left == 0) return;
    track_x    = track_x + slope_x;
    track_y    = track_y + slope_y;
    moves_left = moves_left - PB'(1);
    done       = (moves_left == 0);
    // Arithmetic shift of the signed accumulator floors toward minus infinity.
    fx = track_x >>> FB;
    fy = track_y >>> FB;
    px = int'(fx);
    py = int'(fy);
    case (cur_style)
      dls_pkg::STYLE_SOLID: begin
        push_pixel(px, py, 1'b1, done);
      end
      dls_pkg::STYLE_DOTTED: begin
        if ((px & 1) != 0) push_pixel(px, py, 1'b1, done);
      end
      dls_pkg::STYLE_DASHED: begin
        if (px % 5 != 0) push_pixel(px, py, 1'b1, done);
      end
      default: begin
        push_pixel(px, py, 1'b0, done);
        push_pixel(px + 1, py, 1'b0, done);
        push_pixel(px, py + 1, 1'b0, done);
        push_pixel(px - 1, py, 1'b1, done);
      end
    endcase
  endtask

  task automatic check_pixel();
    pixel_t got, want;
    got = '{x: out_pixel_x, y: out_pixel_y, last: out_last_of_step, done: out_line_done};
    seen_cnt++;
    if (pixel_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= REPORT_LIMIT) begin
        $display("Unexpected pixel x=%0d y=%0d last=%0b done=%0b",
                 got.x, got.y, got.last, got.done);
      end
    end else begin
      want = pixel_q.pop_front();
      if (got !== want) begin
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT) begin
          $display("Pixel mismatch: expected x=%0d y=%0d last=%0b done=%0b",
                   want.x, want.y, want.last, want.done);
          $display("                     got x=%0d y=%0d last=%0b done=%0b",
                   got.x, got.y, got.last, got.done);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_style  = dls_pkg::STYLE_SOLID;
      track_x    = '0;
      track_y    = '0;
      slope_x    = '0;
      slope_y    = '0;
      moves_left = '0;
      err_cnt    = 0;
      seen_cnt   = 0;
      pixel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cur_style = dls_pkg::style_t'(cfg_line_style);
      if (out_valid && !out_stall) check_pixel();
      if (in_valid && !in_stall) begin
        if (in_op == dls_pkg::OP_LOAD) begin
          load_line(in_start_x, in_start_y, in_end_x, in_end_y);
        end else begin
          advance_line();
        end
      end
    end
    mismatches     <= err_cnt;
    pixels_pending <= pixel_q.size();
    pixels_checked <= seen_cnt;
  end

endmodule

[test/tb_top.sv]
// Top of the line stepper testbench: clock, reset, directed and random
// stimulus, style writes and the verdict. Depends on dls_pkg and the checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int CB            = dls_pkg::COORD_BITS;
  localparam int OB            = dls_pkg::OUT_BITS;
  localparam int SB            = dls_pkg::STYLE_BITS;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 48;
  localparam int SEGMENT_ITEMS = 27;
  localparam int NEAR_SPAN     = 12;
  localparam int LONG_STEPS    = 16;
  localparam int COORD_MAX     = (1 << CB) - 1;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_op;
  logic [CB-1:0]        in_start_x;
  logic [CB-1:0]        in_start_y;
  logic [CB-1:0]        in_end_x;
  logic [CB-1:0]        in_end_y;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [OB-1:0] out_pixel_x;
  logic signed [OB-1:0] out_pixel_y;
  logic                 out_last_of_step;
  logic                 out_line_done;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [SB-1:0]        cfg_line_style;

  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              cycle_count   = 0;
  int              load_count    = 0;
  int              step_count    = 0;
  int              mismatches;
  int              pixels_pending;
  int              pixels_checked;
  int              send_pcts [3] = '{30, 46, 0};
  int              recv_pcts [3] = '{46, 30, 0};
  dls_pkg::style_t style_order [3][4];

  dda_line_pixel_stepper i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_last_of_step (out_last_of_step),
    .out_line_done    (out_line_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_line_style   (cfg_line_style)
  );

  dls_pixel_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_last_of_step (out_last_of_step),
    .out_line_done    (out_line_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_line_style   (cfg_line_style),
    .mismatches       (mismatches),
    .pixels_pending   (pixels_pending),
    .pixels_checked   (pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one item after a random gap and returns at the edge that takes it.
  task automatic send_item(input dls_pkg::op_t op, input int sx, input int sy, input int ex,
                           input int ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      in_op      <= 1'($urandom_range(1));
      in_start_x <= CB'($urandom);
      in_end_y   <= CB'($urandom);
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_start_x <= sx[CB-1:0];
    in_start_y <= sy[CB-1:0];
    in_end_x   <= ex[CB-1:0];
    in_end_y   <= ey[CB-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == dls_pkg::OP_LOAD) load_count++;
    else step_count++;
  endtask

  // Waits until every predicted pixel has come out, then lets the block finish
  // any load or skipped-pixel step that produces nothing.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_style(input dls_pkg::style_t s);
    drain();
    cfg_valid      <= 1'b1;
    cfg_line_style <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int coord_near(input int c);
    int v;
    v = c + int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // One load followed by its steps: usually the whole line, sometimes cut
  // short by the next load, sometimes run past its end.
  task automatic run_line(output int used);
    int pick, sx, sy, ex, ey, adx, ady, span, n;
    pick = $urandom_range(99);
    sx   = $urandom_range(COORD_MAX);
    sy   = $urandom_range(COORD_MAX);
    if (pick < 10) begin
      ex = sx;
      ey = sy;
    end else if (pick < 25) begin
      ex = $urandom_range(COORD_MAX);
      ey = $urandom_range(COORD_MAX);
    end else begin
      ex = coord_near(sx);
      ey = coord_near(sy);
    end
    send_item(dls_pkg::OP_LOAD, sx, sy, ex, ey);
    adx  = ex > sx ? ex - sx : sx - ex;
    ady  = ey > sy ? ey - sy : sy - ey;
    span = adx > ady ? adx : ady;
    n    = span;
    if (span > LONG_STEPS) n = $urandom_range(1, LONG_STEPS);
    else if (span > 0 && $urandom_range(7) == 0) n = $urandom_range(span - 1);
    used = 1 + n;
    if ($urandom_range(4) == 0) n += $urandom_range(1, 2);
    repeat (n) send_item(dls_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int used, sent;
    style_order = '{'{dls_pkg::STYLE_SOLID, dls_pkg::STYLE_THICK,
                      dls_pkg::STYLE_DOTTED, dls_pkg::STYLE_DASHED},
                    '{dls_pkg::STYLE_THICK, dls_pkg::STYLE_DASHED,
                      dls_pkg::STYLE_SOLID, dls_pkg::STYLE_DOTTED},
                    '{dls_pkg::STYLE_DASHED, dls_pkg::STYLE_DOTTED,
                      dls_pkg::STYLE_THICK, dls_pkg::STYLE_SOLID}};
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_op          <= dls_pkg::OP_LOAD;
    in_start_x     <= '0;
    in_start_y     <= '0;
    in_end_x       <= '0;
    in_end_y       <= '0;
    cfg_valid      <= 1'b0;
    cfg_line_style <= dls_pkg::STYLE_SOLID;
    send_idle_pct  = send_pcts[0];
    recv_idle_pct  = recv_pcts[0];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: no active line, full-range diagonals both ways, a
    // zero-length line, a short line run past its end and the edge pixels.
    write_style(dls_pkg::STYLE_SOLID);
    send_item(dls_pkg::OP_STEP, 0, 0, 0, 0);
    send_item(dls_pkg::OP_LOAD, 0, 0, COORD_MAX, COORD_MAX);
    repeat (3) send_item(dls_pkg::OP_STEP, 0, 0, 0, 0);
    send_item(dls_pkg::OP_LOAD, COORD_MAX, COORD_MAX, 0, 0);
    repeat (2) send_item(dls_pkg::OP_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(dls_pkg::OP_LOAD, 7, 9, 7, 9);
    send_item(dls_pkg::OP_STEP, 0, 0, 0, 0);
    send_item(dls_pkg::OP_LOAD, 10, 20, 12, 17);
    repeat (4) send_item(dls_pkg::OP_STEP, 0, 0, 0, 0);
    write_style(dls_pkg::STYLE_THICK);
    send_item(dls_pkg::OP_LOAD, 2, 5, 0, 5);
    repeat (2) send_item(dls_pkg::OP_STEP, 0, 0, 0, 0);
    send_item(dls_pkg::OP_LOAD, COORD_MAX - 2, COORD_MAX, COORD_MAX, COORD_MAX);
    repeat (2) send_item(dls_pkg::OP_STEP, 0, 0, 0, 0);
    write_style(dls_pkg::STYLE_DASHED);
    send_item(dls_pkg::OP_LOAD, 3, 0, 5, 0);
    repeat (2) send_item(dls_pkg::OP_STEP, 0, 0, 0, 0);

    for (int phase = 0; phase < 3; phase++) begin
      for (int seg = 0; seg < 4; seg++) begin
        write_style(style_order[phase][seg]);
        send_idle_pct = send_pcts[phase];
        recv_idle_pct = recv_pcts[phase];
        sent = 0;
        while (sent < SEGMENT_ITEMS) begin
          // Occasional stray step: ignored after a finished line.
          if ($urandom_range(99) < 8) begin
            send_item(dls_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom);
          end
          run_line(used);
          sent += used;
        end
      end
    end

    drain();
    $display("Drove %0d loads and %0d steps in all four styles under three idle patterns.",
             load_count, step_count);
    $display("Checked %0d pixels against the predicted stream.", pixels_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
